// ===== hdl/positional_list_engine_unit_macros.svh =====
// ----------------------------------------------------------------------------
// positional_list_engine_unit_macros.svh
// Assertion macros used by ple_ctrl of the positional list engine RTL.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define PLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define PLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PLE_ASSERT(lbl, prop, msg)
`define PLE_ASSERT_IMP(lbl, ante, cons, msg)
`define PLE_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/ple_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Constants, codes and types of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY = 64;
  localparam int ELEM_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int LEN_W    = $clog2(CAPACITY + 1);

  localparam int OP_W     = 3;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int ST_W     = 2;
  localparam int COUNT_W  = 7;
  localparam int CMP_W    = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

  localparam logic [OP_W-1:0] OP_READ      = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT    = 3'd1;
  localparam logic [OP_W-1:0] OP_OVERWRITE = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE    = 3'd3;
  localparam logic [OP_W-1:0] OP_REVERSE   = 3'd4;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

  typedef logic [ELEM_W-1:0] elem_t;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_WRITE,
    ACT_INSERT,
    ACT_DELETE
  } store_act_t;

  typedef struct packed {
    store_act_t       act;
    logic [IDX_W-1:0] idx;
    elem_t            data;
  } store_cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0]  read_value;
    logic [ST_W-1:0]    status;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

// ===== hdl/ple_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_ifs
// Request and result channel interfaces of the positional list engine.
// ----------------------------------------------------------------------------
interface ple_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [6:0]  position;
  logic [31:0] value;

  modport source (output valid, output opcode, output position, output value,
                  input ready);
  modport sink   (input valid, input opcode, input position, input value,
                  output ready);
endinterface

interface ple_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_value;
  logic [1:0]  status;
  logic [6:0]  count;

  modport source (output valid, output read_value, output status, output count,
                  input ready);
  modport sink   (input valid, input read_value, input status, input count,
                  output ready);
endinterface

// ===== hdl/ple_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_store
// Element cells; each cell holds, takes new data or shifts from a neighbor.
// ----------------------------------------------------------------------------
module ple_store
  import ple_pkg::*;
(
  input  logic             clk,
  input  store_cmd_t       cmd,
  input  logic [IDX_W-1:0] rd_idx,
  output elem_t            rd_data
);

  elem_t cells_r [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam int LO = (g == 0) ? 0 : g - 1;
    localparam int HI = (g == CAPACITY - 1) ? g : g + 1;
    localparam logic [IDX_W-1:0] ME = IDX_W'(g);

    always_ff @(posedge clk) begin
      unique case (cmd.act)
        ACT_WRITE: begin
          if (cmd.idx == ME) cells_r[g] <= cmd.data;
        end
        ACT_INSERT: begin
          if (cmd.idx == ME) cells_r[g] <= cmd.data;
          else if (cmd.idx < ME) cells_r[g] <= cells_r[LO];
        end
        ACT_DELETE: begin
          if (cmd.idx <= ME) cells_r[g] <= cells_r[HI];
        end
        default: begin
        end
      endcase
    end
  end

  assign rd_data = cells_r[rd_idx];

endmodule

// ===== hdl/ple_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_ctrl
// Request register, length/direction/null registers and request decode.
// ----------------------------------------------------------------------------
`include "positional_list_engine_unit_macros.svh"

module ple_ctrl
  import ple_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  ple_in_if.sink            in_ch,
  input  logic              cfg_we,
  input  logic [DATA_W-1:0] cfg_wdata,
  input  logic              adv,
  input  elem_t             rd_data,
  output logic [IDX_W-1:0]  rd_idx,
  output store_cmd_t        cmd,
  output logic              req_valid,
  output result_t           res
);

  logic              s1_valid_r;
  logic [OP_W-1:0]   op_r;
  logic [POS_W-1:0]  pos_r;
  elem_t             val_r;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              rev_r, rev_nxt;
  logic [DATA_W-1:0] null_r;

  logic              fire;
  logic [CMP_W-1:0]  pos_x, len_x, phys_x;
  logic              in_list, ins_ok, full;
  logic [IDX_W-1:0]  phys;
  store_act_t        act;
  logic [DATA_W-1:0] rv;
  logic [ST_W-1:0]   st;

  assign in_ch.ready = !s1_valid_r || adv;
  assign fire        = s1_valid_r && adv;
  assign req_valid   = s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      len_r      <= '0;
      rev_r      <= 1'b0;
      null_r     <= '0;
    end else begin
      if (in_ch.ready) s1_valid_r <= in_ch.valid;
      len_r <= len_nxt;
      rev_r <= rev_nxt;
      if (cfg_we) null_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r  <= in_ch.opcode;
      pos_r <= in_ch.position;
      val_r <= ELEM_W'(in_ch.value);
    end
  end

  always_comb begin
    pos_x   = CMP_W'(pos_r);
    len_x   = CMP_W'(len_r);
    in_list = (pos_x != '0) && (pos_x <= len_x);
    ins_ok  = (pos_x != '0) && (pos_x <= len_x + CMP_W'(1));
    full    = (len_r == LEN_W'(CAPACITY));

    // reversed view: logical position p sits at physical len - p
    if (!rev_r) phys_x = pos_x - CMP_W'(1);
    else if (op_r == OP_INSERT) phys_x = len_x - pos_x + CMP_W'(1);
    else phys_x = len_x - pos_x;
    phys = phys_x[IDX_W-1:0];

    act     = ACT_HOLD;
    rv      = '0;
    st      = ST_BADPOS;
    len_nxt = len_r;
    rev_nxt = rev_r;
    unique case (op_r)
      OP_READ: begin
        rv = in_list ? DATA_W'(rd_data) : null_r;
        st = in_list ? ST_OK : ST_BADPOS;
      end
      OP_INSERT: begin
        if (!ins_ok) st = ST_BADPOS;
        else if (full) st = ST_FULL;
        else begin
          st      = ST_OK;
          act     = ACT_INSERT;
          len_nxt = len_r + LEN_W'(1);
        end
      end
      OP_OVERWRITE: begin
        st = in_list ? ST_OK : ST_BADPOS;
        if (in_list) act = ACT_WRITE;
      end
      OP_DELETE: begin
        st = in_list ? ST_OK : ST_BADPOS;
        if (in_list) begin
          act     = ACT_DELETE;
          len_nxt = len_r - LEN_W'(1);
        end
      end
      OP_REVERSE: begin
        st      = ST_OK;
        rev_nxt = !rev_r;
      end
      default: begin
      end
    endcase

    if (!fire) begin
      act     = ACT_HOLD;
      len_nxt = len_r;
      rev_nxt = rev_r;
    end
  end

  assign rd_idx         = phys;
  assign cmd.act        = act;
  assign cmd.idx        = phys;
  assign cmd.data       = val_r;
  assign res.read_value = rv;
  assign res.status     = st;
  assign res.count      = COUNT_W'(len_nxt);

  `PLE_ASSERT(a_len_bound, len_r <= LEN_W'(CAPACITY), "length above capacity")
  `PLE_ASSERT_NXT(a_ins_grow, fire && op_r == OP_INSERT && ins_ok && !full,
                  (len_r - $past(len_r)) == LEN_W'(1), "insert did not grow length")
  `PLE_ASSERT_NXT(a_del_shrink, fire && op_r == OP_DELETE && in_list,
                  ($past(len_r) - len_r) == LEN_W'(1), "delete did not shrink length")
  `PLE_ASSERT_NXT(a_rev_hold, !(fire && op_r == OP_REVERSE), $stable(rev_r),
                  "direction changed without reverse")
  `PLE_ASSERT_IMP(a_store_idle, !fire, cmd.act == ACT_HOLD, "cell update without transfer")

endmodule

// ===== hdl/ple_result.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_result
// Result register feeding the output channel.
// ----------------------------------------------------------------------------
module ple_result
  import ple_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    req_valid,
  input  result_t res,
  output logic    adv,
  ple_out_if.source out_ch
);

  logic    out_valid_r;
  result_t res_r;

  assign adv = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && req_valid) res_r <= res;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = res_r.read_value;
  assign out_ch.status     = res_r.status;
  assign out_ch.count      = res_r.count;

endmodule

// ===== hdl/positional_list_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Bounded ordered list with read, insert, overwrite, delete and reverse by
// 1-based position; one result transfer per request.
// ----------------------------------------------------------------------------
// channel  dir  handshake      payload
// in_ch    in   valid/ready    opcode[2:0] position[6:0] value[31:0]
// out_ch   out  valid/ready    read_value[31:0] status[1:0] count[6:0]
// cfg      in   cfg_we         cfg_wdata[31:0] (null value)
//
// One request per cycle while the result side does not stall; the result is registered.
// Request register -> decode and cell update -> result register.
// Reverse flips a direction bit rather than moving cells, so it is handled like every other opcode.
// Synchronous active-low reset; length, direction and null value clear, cells
// are undefined until written.
// A stalled result holds the request register, which then holds in_ch.
// ----------------------------------------------------------------------------
module positional_list_engine_unit
  import ple_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  ple_in_if.sink            in_ch,
  ple_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [DATA_W-1:0] cfg_wdata
);

  logic             adv;
  logic             req_valid;
  elem_t            rd_data;
  logic [IDX_W-1:0] rd_idx;
  store_cmd_t       cmd;
  result_t          res;

  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .adv       (adv),
    .rd_data   (rd_data),
    .rd_idx    (rd_idx),
    .cmd       (cmd),
    .req_valid (req_valid),
    .res       (res)
  );

  ple_store u_store (
    .clk     (clk),
    .cmd     (cmd),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  ple_result u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .res       (res),
    .adv       (adv),
    .out_ch    (out_ch)
  );

endmodule

// ===== bench/tb_positional_list_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine_unit
// Self-checking bench for the positional list engine.
// ----------------------------------------------------------------------------
// A queue of requests is filled per phase and drained by a bursty driver into
// in_ch. A clocked monitor predicts each accepted request against its own
// copy of the list and compares every out_ch transfer with the oldest
// prediction. The result side stalls on a changing pattern. Between phases
// the bench drains all results, then rewrites the null value register.
// Phases: directed corner cases, an insert-heavy sweep up to capacity, a
// delete-heavy sweep back to empty, then a balanced mix.
// ----------------------------------------------------------------------------
module tb_positional_list_engine_unit;
  import ple_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE       = 4;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] value;
  } list_req_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [DATA_W-1:0] cfg_wdata;

  ple_in_if  in_if ();
  ple_out_if out_if ();

  positional_list_engine_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // predicted list contents
  elem_t             list_cells[CAPACITY];
  int                list_len;
  logic [DATA_W-1:0] null_val;

  list_req_t   req_q[$];
  result_t     result_q[$];
  int          gen_len;
  int          n_queued;
  int          n_accepted;
  int          errors;
  int          cycles;
  bit          in_taken;

  int          gap_left;
  int          burst_left;
  int          rx_mode;
  int          rx_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t apply_list_op(list_req_t r);
    result_t res;
    int      p;
    bit      in_list;
    elem_t   t;
    int      a;
    int      b;
    p       = r.position;
    in_list = (p >= 1) && (p <= list_len);
    res     = '0;
    res.status = ST_OK;
    case (r.opcode)
      OP_READ: begin
        if (in_list) begin
          res.read_value = list_cells[p - 1];
        end else begin
          res.read_value = null_val;
          res.status     = ST_BADPOS;
        end
      end
      OP_INSERT: begin
        if (p < 1 || p > list_len + 1) begin
          res.status = ST_BADPOS;
        end else if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (int k = list_len; k >= p; k--) list_cells[k] = list_cells[k - 1];
          list_cells[p - 1] = r.value;
          list_len++;
        end
      end
      OP_OVERWRITE: begin
        if (in_list) list_cells[p - 1] = r.value;
        else res.status = ST_BADPOS;
      end
      OP_DELETE: begin
        if (in_list) begin
          for (int k = p; k < list_len; k++) list_cells[k - 1] = list_cells[k];
          list_len--;
        end else begin
          res.status = ST_BADPOS;
        end
      end
      OP_REVERSE: begin
        a = 0;
        b = list_len - 1;
        while (a < b) begin
          t             = list_cells[a];
          list_cells[a] = list_cells[b];
          list_cells[b] = t;
          a++;
          b--;
        end
      end
      default: res.status = ST_BADPOS;
    endcase
    res.count = COUNT_W'(list_len);
    return res;
  endfunction

  task automatic push_req(logic [OP_W-1:0] op, int pos, logic [DATA_W-1:0] val);
    list_req_t r;
    r.opcode   = op;
    r.position = POS_W'(pos);
    r.value    = val;
    req_q.push_back(r);
    n_queued++;
    // track length at generation time so positions can be aimed
    if (op == OP_INSERT && pos >= 1 && pos <= gen_len + 1 && gen_len < CAPACITY)
      gen_len++;
    else if (op == OP_DELETE && pos >= 1 && pos <= gen_len)
      gen_len--;
  endtask

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_random(int n, int ins_w, int del_w);
    logic [OP_W-1:0] op;
    int              r;
    int              hi;
    int              pos;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        op  = OP_W'($urandom_range(0, 2**OP_W - 1));
        pos = $urandom_range(0, 2**POS_W - 1);
      end else begin
        r = $urandom_range(0, 45 + ins_w + del_w - 1);
        if (r < 25)                      op = OP_READ;
        else if (r < 40)                 op = OP_OVERWRITE;
        else if (r < 45)                 op = OP_REVERSE;
        else if (r < 45 + ins_w)         op = OP_INSERT;
        else                             op = OP_DELETE;
        hi = (op == OP_INSERT) ? gen_len + 1 : gen_len;
        if (hi == 0) begin
          pos = $urandom_range(0, 2**POS_W - 1);
        end else begin
          case ($urandom_range(0, 9))
            0:       pos = 1;
            1:       pos = hi;
            default: pos = $urandom_range(1, hi);
          endcase
        end
      end
      push_req(op, pos, rand_value());
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (n_accepted != n_queued || result_q.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_null(logic [DATA_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // request driver and result-side stall pattern
  always @(negedge clk) begin
    list_req_t r;
    bit        rdy;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (req_q.size() > 0) begin
        r = req_q.pop_front();
        in_if.opcode   <= r.opcode;
        in_if.position <= r.position;
        in_if.value    <= r.value;
        in_if.valid    <= 1'b1;
        if (burst_left == 0) burst_left = $urandom_range(1, 16);
        burst_left--;
        if (burst_left == 0)
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        in_if.valid <= 1'b0;
      end
    end

    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(16, 80);
    end
    rx_left--;
    case (rx_mode)
      0:       rdy = 1'b1;
      1:       rdy = ($urandom_range(0, 9) < 7);
      2:       rdy = (rx_left % 4 == 0);
      default: rdy = (rx_left % 12 < 3);
    endcase
    out_if.ready <= rdy;
  end

  // monitor: predict on request transfer, check on result transfer
  always @(posedge clk) begin
    result_t got;
    result_t want;
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("tb_positional_list_engine_unit NOT OK");
      $finish;
    end else if (rst_n) begin
      if (cfg_we) null_val = cfg_wdata;
      in_taken = in_if.valid && in_if.ready;
      if (in_taken) begin
        result_q.push_back(apply_list_op({in_if.opcode, in_if.position, in_if.value}));
        n_accepted++;
      end
      if (out_if.valid && out_if.ready) begin
        got.read_value = out_if.read_value;
        got.status     = out_if.status;
        got.count      = out_if.count;
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result rv=%h st=%0d cnt=%0d", $time,
                   got.read_value, got.status, got.count);
        end else begin
          want = result_q.pop_front();
          if (got.read_value !== want.read_value) begin
            errors++;
            $display("%0t: read_value exp %h got %h", $time, want.read_value,
                     got.read_value);
          end
          if (got.status !== want.status) begin
            errors++;
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          end
          if (got.count !== want.count) begin
            errors++;
            $display("%0t: count exp %0d got %0d", $time, want.count, got.count);
          end
        end
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_if.valid    = 1'b0;
    in_if.opcode   = OP_READ;
    in_if.position = '0;
    in_if.value    = '0;
    out_if.ready   = 1'b0;
    list_len       = 0;
    null_val       = '0;
    gen_len        = 0;
    n_queued       = 0;
    n_accepted     = 0;
    errors         = 0;
    cycles         = 0;
    in_taken       = 1'b0;
    gap_left       = 0;
    burst_left     = 0;
    rx_mode        = 0;
    rx_left        = 0;

    // corner cases on an empty, single and short list; null value at reset
    push_req(OP_READ,      1,   32'h1111_1111);
    push_req(OP_DELETE,    1,   '0);
    push_req(OP_OVERWRITE, 1,   32'h2222_2222);
    push_req(OP_REVERSE,   0,   '0);
    push_req(OP_INSERT,    0,   32'h3333_3333);
    push_req(OP_INSERT,    2,   32'h4444_4444);
    push_req(OP_INSERT,    1,   '0);
    push_req(OP_REVERSE,   127, '1);
    push_req(OP_INSERT,    2,   '1);
    push_req(OP_INSERT,    1,   32'h1234_5678);
    push_req(OP_READ,      1,   '0);
    push_req(OP_READ,      3,   '0);
    push_req(OP_READ,      4,   '0);
    push_req(OP_REVERSE,   5,   '0);
    push_req(OP_READ,      1,   '0);
    push_req(OP_OVERWRITE, 3,   32'ha5a5_a5a5);
    push_req(OP_OVERWRITE, 4,   32'h5a5a_5a5a);
    push_req(OP_DELETE,    2,   '0);
    push_req(OP_READ,      2,   '0);
    push_req(OP_READ,      127, '0);
    for (int o = OP_REVERSE + 1; o < 2**OP_W; o++) push_req(OP_W'(o), 1, '1);
    push_req(OP_DELETE,    2,   '0);
    push_req(OP_INSERT,    127, 32'h5a5a_5a5a);
    push_req(OP_READ,      1,   '0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait_drained();

    write_null('1);
    add_random(300, 45, 10);
    wait_drained();

    write_null('0);
    add_random(300, 10, 40);
    wait_drained();

    write_null($urandom);
    add_random(160, 30, 25);
    add_random(165, 25, 30);
    wait_drained();

    if (errors == 0) begin
      $display("tb_positional_list_engine_unit OK");
    end else begin
      $display("tb_positional_list_engine_unit NOT OK");
    end
    $finish;
  end

endmodule
